>>> rtl/spi_rrm_pkg.sv
// Shared types and constants for the SPI register read master.
// Used by every module of the block but the checker; depends on nothing.
package spi_rrm_pkg;

  // Bits per serial frame (address frame and data frame alike).
  localparam int unsigned FrameBits = 8;
  // Width of the bit counter within one frame.
  localparam int unsigned BitCntW = $clog2(FrameBits + 1);
  // Read flag set in the top bit of the address frame.
  localparam logic [7:0] ReadFlag = 8'h80;
  // Width of the configuration data and half-period counter.
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CLOCK_POLARITY    = 2'd0,
    CFG_CLOCK_PHASE       = 2'd1,
    CFG_THREE_WIRE        = 2'd2,
    CFG_HALF_PERIOD_TICKS = 2'd3
  } cfg_idx_e;

  // Transaction phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ADDR = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  typedef struct packed {
    logic                clock_polarity;
    logic                clock_phase;
    logic                three_wire;
    logic [CfgDataW-1:0] half_period_ticks;
  } cfg_t;

  // One timing tick as it enters the block.
  typedef struct packed {
    logic       start_req;
    logic [6:0] reg_addr;
    logic       miso_level;
    logic       sdio_level;
  } item_t;

  // Pin and status levels after one tick.
  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi_level;
    logic       mosi_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

endpackage

>>> rtl/spi_register_read_master.sv
// SPI register read master: each input beat is one timing tick, each tick
// gives one result beat with the pin levels after that tick.
// Path: an accepted tick waits in the input register, then the sequencer
// update is loaded into the result register, which offers the result beat.
// Throughput: one tick per cycle while the result side takes its beats.
// Reset: asynchronous, active low; sequencer idle, no beat held, half-period one.
module spi_register_read_master (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [spi_rrm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             start_req_i,
  input  logic [6:0]                       reg_addr_i,
  input  logic                             miso_level_i,
  input  logic                             sdio_level_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             cs_n_o,
  output logic                             sclk_o,
  output logic                             mosi_level_o,
  output logic                             mosi_drive_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic [7:0]                       read_data_o
);

  spi_rrm_pkg::cfg_t  cfg;
  spi_rrm_pkg::item_t item_in;
  spi_rrm_pkg::item_t item_q;
  spi_rrm_pkg::res_t  res_d;
  spi_rrm_pkg::res_t  res_q;
  logic               item_valid;
  logic               out_ready;
  logic               step;

  assign item_in = '{start_req:  start_req_i,
                     reg_addr:   reg_addr_i,
                     miso_level: miso_level_i,
                     sdio_level: sdio_level_i};

  // A held tick moves into the sequencer when the result register has room.
  assign step = item_valid && out_ready;

  spi_rrm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  spi_rrm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (step),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  spi_rrm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  spi_rrm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_d),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign cs_n_o       = res_q.cs_n;
  assign sclk_o       = res_q.sclk;
  assign mosi_level_o = res_q.mosi_level;
  assign mosi_drive_o = res_q.mosi_drive;
  assign busy_res_o   = res_q.busy_res;
  assign done_res_o   = res_q.done_res;
  assign read_data_o  = res_q.read_data;

endmodule

>>> rtl/spi_rrm_cfg.sv
// Configuration register file of the SPI register read master.
// Depends on spi_rrm_pkg for the register indexes and the cfg_t type.
module spi_rrm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [spi_rrm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output spi_rrm_pkg::cfg_t                  cfg_o
);

  spi_rrm_pkg::cfg_t cfg_q;

  // Register writes; the index decodes to one register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_polarity    <= 1'b0;
      cfg_q.clock_phase       <= 1'b0;
      cfg_q.three_wire        <= 1'b0;
      cfg_q.half_period_ticks <= spi_rrm_pkg::CfgDataW'(1);
    end else if (cfg_we_i) begin
      unique case (spi_rrm_pkg::cfg_idx_e'(cfg_idx_i))
        spi_rrm_pkg::CFG_CLOCK_POLARITY:    cfg_q.clock_polarity    <= cfg_wdata_i[0];
        spi_rrm_pkg::CFG_CLOCK_PHASE:       cfg_q.clock_phase       <= cfg_wdata_i[0];
        spi_rrm_pkg::CFG_THREE_WIRE:        cfg_q.three_wire        <= cfg_wdata_i[0];
        spi_rrm_pkg::CFG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/spi_rrm_in_reg.sv
// Input register stage: holds one accepted tick until the sequencer takes it.
// Depends on spi_rrm_pkg for the item_t type.
module spi_rrm_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spi_rrm_pkg::item_t  item_i,
  input  logic                take_i,
  output logic                valid_o,
  output spi_rrm_pkg::item_t  item_o
);

  logic               valid_q;
  spi_rrm_pkg::item_t item_q;
  logic               load;

  // The stage is free when empty or when its beat moves on this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/spi_rrm_seq.sv
// Transaction sequencer: state registers and the per-tick update that
// drives the serial clock, shifts the address out and the data byte in.
// Depends on spi_rrm_pkg for types and frame constants.
module spi_rrm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  spi_rrm_pkg::item_t  item_i,
  input  spi_rrm_pkg::cfg_t   cfg_i,
  output spi_rrm_pkg::res_t   res_o
);

  spi_rrm_pkg::phase_e                phase_q, phase_d;
  logic [spi_rrm_pkg::BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [7:0]                         tx_q, tx_d;
  logic [7:0]                         rx_q, rx_d;
  logic [spi_rrm_pkg::CfgDataW-1:0]   tick_q, tick_d;
  logic                               half_q, half_d;

  logic [spi_rrm_pkg::CfgDataW-1:0]   period;
  logic [spi_rrm_pkg::CfgDataW:0]     tick_inc;
  logic [spi_rrm_pkg::BitCntW:0]      bit_next;
  logic                               busy, busy_d;
  logic                               line;
  logic                               done;

  // A zero half-period behaves as one tick.
  assign period   = (cfg_i.half_period_ticks == '0) ? spi_rrm_pkg::CfgDataW'(1)
                                                    : cfg_i.half_period_ticks;
  assign tick_inc = {1'b0, tick_q} + (spi_rrm_pkg::CfgDataW + 1)'(1);
  assign bit_next = {1'b0, bit_cnt_q} + (spi_rrm_pkg::BitCntW + 1)'(1);
  assign line     = cfg_i.three_wire ? item_i.sdio_level : item_i.miso_level;
  assign busy     = (phase_q == spi_rrm_pkg::PH_ADDR) || (phase_q == spi_rrm_pkg::PH_DATA);

  // Next state for one tick.
  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    tick_d    = tick_q;
    half_d    = half_q;
    done      = 1'b0;
    if (busy) begin
      if (tick_inc >= {1'b0, period}) begin
        tick_d = '0;
        if (!half_q) begin
          // End of the first half: sample the slave line in the data frame.
          half_d = 1'b1;
          if (phase_q == spi_rrm_pkg::PH_DATA) begin
            rx_d = {rx_q[6:0], line};
          end
        end else begin
          // End of the bit: shift the address, step the bit or the phase.
          half_d = 1'b0;
          if (phase_q == spi_rrm_pkg::PH_ADDR) begin
            tx_d = {tx_q[6:0], 1'b0};
          end
          if (bit_next >= (spi_rrm_pkg::BitCntW + 1)'(spi_rrm_pkg::FrameBits)) begin
            bit_cnt_d = '0;
            if (phase_q == spi_rrm_pkg::PH_ADDR) begin
              phase_d = spi_rrm_pkg::PH_DATA;
            end else begin
              phase_d = spi_rrm_pkg::PH_IDLE;
              done    = 1'b1;
            end
          end else begin
            bit_cnt_d = bit_next[spi_rrm_pkg::BitCntW-1:0];
          end
        end
      end else begin
        tick_d = tick_inc[spi_rrm_pkg::CfgDataW-1:0];
      end
    end else begin
      phase_d = spi_rrm_pkg::PH_IDLE;
      if (item_i.start_req) begin
        phase_d   = spi_rrm_pkg::PH_ADDR;
        tx_d      = spi_rrm_pkg::ReadFlag | {1'b0, item_i.reg_addr};
        rx_d      = '0;
        bit_cnt_d = '0;
        tick_d    = '0;
        half_d    = 1'b0;
      end
    end
  end

  // Pin levels show the state after this tick.
  assign busy_d = (phase_d == spi_rrm_pkg::PH_ADDR) || (phase_d == spi_rrm_pkg::PH_DATA);

  always_comb begin
    res_o.cs_n       = !busy_d;
    res_o.sclk       = busy_d ? (cfg_i.clock_polarity ^ cfg_i.clock_phase ^ half_d)
                              : cfg_i.clock_polarity;
    res_o.mosi_level = (phase_d == spi_rrm_pkg::PH_ADDR) ? tx_d[7] : 1'b0;
    res_o.mosi_drive = !((phase_d == spi_rrm_pkg::PH_DATA) && cfg_i.three_wire);
    res_o.busy_res   = busy_d;
    res_o.done_res   = done;
    res_o.read_data  = done ? rx_q : 8'h00;
  end

  // State update on each tick that the sequencer takes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= spi_rrm_pkg::PH_IDLE;
      bit_cnt_q <= '0;
      tx_q      <= '0;
      rx_q      <= '0;
      tick_q    <= '0;
      half_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      tx_q      <= tx_d;
      rx_q      <= rx_d;
      tick_q    <= tick_d;
      half_q    <= half_d;
    end
  end

endmodule

>>> rtl/spi_rrm_out_reg.sv
// Result register: holds one result beat until the receiver takes it.
// Depends on spi_rrm_pkg for the res_t type.
module spi_rrm_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  spi_rrm_pkg::res_t  res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spi_rrm_pkg::res_t  res_o
);

  logic              valid_q;
  spi_rrm_pkg::res_t res_q;

  // A new beat may enter when empty or when the held beat leaves now.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/spi_rrm_checker.sv
// Port-level checks for the SPI register read master, bound to the top level.
// Depends only on the port names of spi_register_read_master.
module spi_rrm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       cs_n_o,
  input logic       mosi_drive_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] read_data_o
);

  // Chip select is low exactly while a read is under way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cs_n_o == !busy_res_o))
    else $error("chip select disagrees with busy");

  // The completing beat already shows the bus released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (cs_n_o && !busy_res_o && mosi_drive_o))
    else $error("done beat while bus still held");

  // The data line is released only inside a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mosi_drive_o) |-> busy_res_o)
    else $error("data line released while idle");

  // Read data is zero on every beat but the completing one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (read_data_o == 8'h00))
    else $error("read data without done");

  // A stalled result beat stays and holds its read data, done flag and chip select.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)
                                      && $stable(done_res_o) && $stable(cs_n_o)))
    else $error("stalled result beat changed");

endmodule

bind spi_register_read_master spi_rrm_checker u_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for the SPI register read master: random ticks with
// gaps and result stalls, every result beat checked against a local predictor.
// Depends on rtl/spi_rrm_pkg.sv and rtl/spi_register_read_master.sv.
module tb;

  localparam int unsigned WatchdogLimit = 5000;

  // Tracks the sequencer state and holds the pin levels expected per tick.
  class read_tracker;
    spi_rrm_pkg::cfg_t               cfg;
    spi_rrm_pkg::phase_e             seq_phase;
    logic [spi_rrm_pkg::BitCntW-1:0] bit_cnt;
    logic [7:0]                      addr_sr;
    logic [7:0]                      data_sr;
    logic [15:0]                     tick_cnt;
    logic                            second_half;
    spi_rrm_pkg::res_t               expected_pins_q[$];
    int                              mismatches;

    function new();
      cfg         = '{clock_polarity: 1'b0, clock_phase: 1'b0, three_wire: 1'b0,
                      half_period_ticks: 16'd1};
      seq_phase   = spi_rrm_pkg::PH_IDLE;
      bit_cnt     = '0;
      addr_sr     = '0;
      data_sr     = '0;
      tick_cnt    = '0;
      second_half = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(spi_rrm_pkg::cfg_idx_e idx,
                          logic [spi_rrm_pkg::CfgDataW-1:0] val);
      case (idx)
        spi_rrm_pkg::CFG_CLOCK_POLARITY:    cfg.clock_polarity = val[0];
        spi_rrm_pkg::CFG_CLOCK_PHASE:       cfg.clock_phase = val[0];
        spi_rrm_pkg::CFG_THREE_WIRE:        cfg.three_wire = val[0];
        spi_rrm_pkg::CFG_HALF_PERIOD_TICKS: cfg.half_period_ticks = val;
        default: ;
      endcase
    endfunction

    // Advances the sequencer by one tick and returns the pin levels after it.
    function spi_rrm_pkg::res_t next_pins(spi_rrm_pkg::item_t tick);
      int unsigned       period;
      int unsigned       next_bit;
      logic              done;
      logic [7:0]        rx_byte;
      logic              busy;
      spi_rrm_pkg::res_t pins;
      period  = (cfg.half_period_ticks == '0) ? 1 : int'(cfg.half_period_ticks);
      done    = 1'b0;
      rx_byte = '0;
      if (seq_phase == spi_rrm_pkg::PH_ADDR || seq_phase == spi_rrm_pkg::PH_DATA) begin
        if (int'(tick_cnt) + 1 >= period) begin
          tick_cnt = '0;
          if (!second_half) begin
            // The slave line is sampled where the first half of the bit ends.
            second_half = 1'b1;
            if (seq_phase == spi_rrm_pkg::PH_DATA) begin
              data_sr = {data_sr[6:0],
                         cfg.three_wire ? tick.sdio_level : tick.miso_level};
            end
          end else begin
            next_bit    = int'(bit_cnt) + 1;
            second_half = 1'b0;
            if (seq_phase == spi_rrm_pkg::PH_ADDR) addr_sr = addr_sr << 1;
            if (next_bit >= spi_rrm_pkg::FrameBits) begin
              bit_cnt = '0;
              if (seq_phase == spi_rrm_pkg::PH_ADDR) begin
                seq_phase = spi_rrm_pkg::PH_DATA;
              end else begin
                seq_phase = spi_rrm_pkg::PH_IDLE;
                done      = 1'b1;
                rx_byte   = data_sr;
              end
            end else begin
              bit_cnt = next_bit[spi_rrm_pkg::BitCntW-1:0];
            end
          end
        end else begin
          tick_cnt = tick_cnt + 16'd1;
        end
      end else if (tick.start_req) begin
        seq_phase   = spi_rrm_pkg::PH_ADDR;
        addr_sr     = {1'b0, tick.reg_addr} | spi_rrm_pkg::ReadFlag;
        data_sr     = '0;
        bit_cnt     = '0;
        tick_cnt    = '0;
        second_half = 1'b0;
      end

      busy            = (seq_phase == spi_rrm_pkg::PH_ADDR ||
                         seq_phase == spi_rrm_pkg::PH_DATA);
      pins.cs_n       = !busy;
      pins.sclk       = busy ? (cfg.clock_polarity ^ cfg.clock_phase ^ second_half)
                             : cfg.clock_polarity;
      pins.mosi_level = (seq_phase == spi_rrm_pkg::PH_ADDR) ? addr_sr[7] : 1'b0;
      pins.mosi_drive = !(seq_phase == spi_rrm_pkg::PH_DATA && cfg.three_wire);
      pins.busy_res   = busy;
      pins.done_res   = done;
      pins.read_data  = rx_byte;
      return pins;
    endfunction

    function void note_tick(spi_rrm_pkg::item_t tick);
      expected_pins_q.push_back(next_pins(tick));
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pins(spi_rrm_pkg::res_t got);
      spi_rrm_pkg::res_t want;
      if (expected_pins_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = expected_pins_q.pop_front();
        field_check("cs_n", 8'(want.cs_n), 8'(got.cs_n));
        field_check("sclk", 8'(want.sclk), 8'(got.sclk));
        field_check("mosi_level", 8'(want.mosi_level), 8'(got.mosi_level));
        field_check("mosi_drive", 8'(want.mosi_drive), 8'(got.mosi_drive));
        field_check("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        field_check("done_res", 8'(want.done_res), 8'(got.done_res));
        field_check("read_data", want.read_data, got.read_data);
      end
    endfunction
  endclass

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             cfg_we_i     = 1'b0;
  logic [1:0]                       cfg_idx_i    = '0;
  logic [spi_rrm_pkg::CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_stall_o;
  logic                             start_req_i  = 1'b0;
  logic [6:0]                       reg_addr_i   = '0;
  logic                             miso_level_i = 1'b0;
  logic                             sdio_level_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i  = 1'b0;
  logic                             cs_n_o;
  logic                             sclk_o;
  logic                             mosi_level_o;
  logic                             mosi_drive_o;
  logic                             busy_res_o;
  logic                             done_res_o;
  logic [7:0]                       read_data_o;

  read_tracker tracker = new();
  int          ticks_sent  = 0;
  int          cycle_cnt   = 0;
  int          quiet_cnt   = 0;
  int          stall_left  = 0;

  spi_register_read_master dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_req_i  (start_req_i),
    .reg_addr_i   (reg_addr_i),
    .miso_level_i (miso_level_i),
    .sdio_level_i (sdio_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cs_n_o       (cs_n_o),
    .sclk_o       (sclk_o),
    .mosi_level_o (mosi_level_o),
    .mosi_drive_o (mosi_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note every accepted tick and check every accepted result beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.note_tick('{start_req: start_req_i, reg_addr: reg_addr_i,
                            miso_level: miso_level_i, sdio_level: sdio_level_i});
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_pins('{cs_n: cs_n_o, sclk: sclk_o, mosi_level: mosi_level_o,
                             mosi_drive: mosi_drive_o, busy_res: busy_res_o,
                             done_res: done_res_o, read_data: read_data_o});
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
    end
    if (quiet_cnt >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result back-pressure: calm stretches alternate with random stalls.
  always @(posedge clk_i) begin : result_backpressure
    int pick;
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (((cycle_cnt / 400) % 3) == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      pick = $urandom_range(0, 15);
      if (pick == 0) stall_left = $urandom_range(10, 40);
      else if (pick < 4) stall_left = $urandom_range(1, 3);
      else stall_left = 0;
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Gap before the next tick: none in calm stretches, else mostly none, sometimes short or long.
  function automatic int tick_gap();
    int pick;
    if (((ticks_sent / 120) % 3) == 0) return 0;
    pick = $urandom_range(0, 15);
    if (pick == 0) return $urandom_range(15, 40);
    if (pick < 5) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Offers one tick beat and returns at the edge where it is taken.
  task automatic send_tick(logic start, logic [6:0] addr, logic miso, logic sdio);
    int gap;
    gap = tick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_req_i  <= start;
    reg_addr_i   <= addr;
    miso_level_i <= miso;
    sdio_level_i <= sdio;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every expected beat has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_pins_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(spi_rrm_pkg::cfg_idx_e idx,
                           logic [spi_rrm_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  // One phase: new settings, then random ticks with the given start weight.
  task automatic run_phase(logic cpol, logic cpha, logic three_w,
                           logic [spi_rrm_pkg::CfgDataW-1:0] half_ticks, int n_ticks,
                           int start_weight);
    settle();
    write_reg(spi_rrm_pkg::CFG_CLOCK_POLARITY, {{(spi_rrm_pkg::CfgDataW-1){1'b0}}, cpol});
    write_reg(spi_rrm_pkg::CFG_CLOCK_PHASE, {{(spi_rrm_pkg::CfgDataW-1){1'b0}}, cpha});
    write_reg(spi_rrm_pkg::CFG_THREE_WIRE, {{(spi_rrm_pkg::CfgDataW-1){1'b0}}, three_w});
    write_reg(spi_rrm_pkg::CFG_HALF_PERIOD_TICKS, half_ticks);
    cfg_we_i <= 1'b0;
    repeat (n_ticks) begin
      send_tick($urandom_range(0, 7) < start_weight, 7'($urandom_range(0, 127)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: an idle tick, a read of the top address, then starts
    // offered while busy with alternating slave levels.
    send_tick(1'b0, 7'd0, 1'b1, 1'b1);
    send_tick(1'b1, 7'h7F, 1'b1, 1'b0);
    for (int i = 0; i < 23; i++) begin
      send_tick(1'b1, 7'd0, i[0], !i[0]);
    end

    // Extreme settings first, including a zero and a maximal half-period
    // that leaves a read in progress across the next change of settings.
    run_phase(1'b0, 1'b0, 1'b0, 16'd0, 200, 4);
    run_phase(1'b1, 1'b0, 1'b1, 16'd1, 200, 7);
    run_phase(1'b0, 1'b1, 1'b1, 16'd2, 200, 2);
    run_phase(1'b1, 1'b1, 1'b1, 16'hFFFF, 60, 8);
    run_phase(1'b1, 1'b1, 1'b0, 16'd3, 200, 5);
    repeat (4) begin
      run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 16'($urandom_range(0, 4)), 140,
                $urandom_range(1, 8));
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/spi_rrm_pkg.sv
rtl/spi_rrm_cfg.sv
rtl/spi_rrm_in_reg.sv
rtl/spi_rrm_seq.sv
rtl/spi_rrm_out_reg.sv
rtl/spi_register_read_master.sv
rtl/spi_rrm_checker.sv
sim/tb.sv
